FILE: design/stsc_pkg.sv
// Shared types, token codes and character tables for the source token scanner.
// No dependencies; imported by stsc_front, stsc_back and source_token_scanner.
package stsc_pkg;

    localparam int MAX_TOKEN_LEN = 32;
    localparam int VALUE_BITS    = 32;
    localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
    localparam int IDX_W         = $clog2(MAX_TOKEN_LEN);
    localparam int KW_N          = 10;

    // front queue, power of two deep
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);

    // token kinds
    localparam logic [4:0] K_SINGLE  = 5'd0;
    localparam logic [4:0] K_LE      = 5'd11;
    localparam logic [4:0] K_EQ      = 5'd12;
    localparam logic [4:0] K_NE      = 5'd13;
    localparam logic [4:0] K_GE      = 5'd14;
    localparam logic [4:0] K_SHL     = 5'd15;
    localparam logic [4:0] K_SHR     = 5'd16;
    localparam logic [4:0] K_AND     = 5'd17;
    localparam logic [4:0] K_OR      = 5'd18;
    localparam logic [4:0] K_IDENT   = 5'd19;
    localparam logic [4:0] K_NUMBER  = 5'd20;
    localparam logic [4:0] K_STREND  = 5'd21;
    localparam logic [4:0] K_EOL     = 5'd22;
    localparam logic [4:0] K_TEXT    = 5'd23;
    localparam logic [4:0] K_STRCHAR = 5'd24;
    localparam logic [4:0] K_ERROR   = 5'd25;

    // error codes
    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_IDENT_LEN = 3'd1;
    localparam logic [2:0] E_STR_LEN   = 3'd2;
    localparam logic [2:0] E_STR_OPEN  = 3'd3;
    localparam logic [2:0] E_BAD_CHAR  = 3'd4;

    // characters with a role of their own
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;

    typedef struct packed {
        logic       space;
        logic       digit;
        logic       ident;
        logic       hex_ok;
        logic [3:0] hex_val;
    } t_cls;

    typedef struct packed {
        logic [7:0] c;
        logic       eol;
        t_cls       cls;
    } t_item;

    function automatic t_cls classify(input logic [7:0] c);
        t_cls r;
        r = '0;
        r.space = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
        r.digit = (c >= "0" && c <= "9");
        r.ident = r.digit || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == CH_UNDER);
        if (r.digit) begin
            r.hex_ok  = 1'b1;
            r.hex_val = 4'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            r.hex_ok  = 1'b1;
            r.hex_val = 4'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            r.hex_ok  = 1'b1;
            r.hex_val = 4'(c - "A" + 8'd10);
        end
        return r;
    endfunction

    // keyword spelling, left aligned in six bytes
    function automatic logic [47:0] kw_word(input int k);
        case (k)
            0: return {"def", 24'h0};
            1: return {"var", 24'h0};
            2: return {"if", 32'h0};
            3: return {"else", 16'h0};
            4: return {"for", 24'h0};
            5: return {"do", 32'h0};
            6: return {"while", 8'h0};
            7: return {"goto", 16'h0};
            8: return "return";
            default: return {"print", 8'h0};
        endcase
    endfunction

    function automatic logic [2:0] kw_len(input int k);
        case (k)
            0, 1, 4: return 3'd3;
            2, 5:    return 3'd2;
            3, 7:    return 3'd4;
            6, 9:    return 3'd5;
            default: return 3'd6;
        endcase
    endfunction

    function automatic logic [7:0] escape_of(input logic [7:0] c);
        case (c)
            "n":     return 8'd10;
            "r":     return 8'd13;
            "t":     return 8'd9;
            default: return c;
        endcase
    endfunction

endpackage

FILE: design/source_token_scanner.sv
// Top level of the source token scanner: joins the classifying front queue
// and the token builder. Depends on stsc_pkg, stsc_front and stsc_back.
//
// Input channel: one source byte or end-of-line mark per word (i_valid,
// o_stall, i_char_in, i_end_of_line). Output channel: token results
// (o_valid, i_stall and the result fields); o_last_result flags the final
// result caused by an input word. A word may cause no result or up to 35.
// Order of work: a word is fetched from the four-entry queue, the builder
// runs its steps (one per result, plus steps that emit nothing, such as
// closing a number before the next token), and its final result is
// released; only then is the next word fetched. A word and its results
// pass through the queue, builder step, hold stage and output register.
// Reset clears the queue, comment and scanner state; the text store is
// not cleared. When the receiver stalls, the output register holds, the
// builder stops at its next result, and the queue fills and then raises
// o_stall.
module source_token_scanner import stsc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_char_in,
    input  logic                  i_end_of_line,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [4:0]            o_token_kind,
    output logic [7:0]            o_char_code,
    output logic [VALUE_BITS-1:0] o_number_value,
    output logic                  o_number_overflow,
    output logic [5:0]            o_text_length,
    output logic [2:0]            o_error_code,
    output logic                  o_last_result
);
    logic  q_valid, q_pop;
    t_item q_item;

    stsc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_char_in     (i_char_in),
        .i_end_of_line (i_end_of_line),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item),
        .i_q_pop       (q_pop)
    );

    stsc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_item          (q_item),
        .o_q_pop           (q_pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_token_kind      (o_token_kind),
        .o_char_code       (o_char_code),
        .o_number_value    (o_number_value),
        .o_number_overflow (o_number_overflow),
        .o_text_length     (o_text_length),
        .o_error_code      (o_error_code),
        .o_last_result     (o_last_result)
    );

endmodule

FILE: design/stsc_front.sv
// Front part of the scanner: accepts source words, classifies the byte and
// queues the result. Depends on stsc_pkg.
module stsc_front import stsc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_end_of_line,
    output logic       o_q_valid,
    output t_item      o_q_item,
    input  logic       i_q_pop
);
    t_item              r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_PTR_W:0]   r_cnt;
    logic               push, pop;

    assign o_stall   = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign push      = i_valid && !o_stall;
    assign pop       = i_q_pop && (r_cnt != '0);
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_q[r_rp];

    // store classified words
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{c: i_char_in, eol: i_end_of_line, cls: classify(i_char_in)};
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + Q_PTR_W'(1);
            if (pop)  r_rp <= r_rp + Q_PTR_W'(1);
            r_cnt <= r_cnt + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
        end
    end

endmodule

FILE: design/stsc_back.sv
// Back part of the scanner: comment stripping and token building (one step
// per cycle unless stalled); hold stage marks last result. Depends on stsc_pkg.
module stsc_back import stsc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_item                 i_q_item,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [4:0]            o_token_kind,
    output logic [7:0]            o_char_code,
    output logic [VALUE_BITS-1:0] o_number_value,
    output logic                  o_number_overflow,
    output logic [5:0]            o_text_length,
    output logic [2:0]            o_error_code,
    output logic                  o_last_result
);
    typedef enum logic [3:0] {
        M_IDLE, M_OP, M_ZERO, M_DEC, M_HEX, M_BIN, M_IDENT, M_STR, M_STRESC,
        M_CHOPEN, M_CHESC, M_CHCLOSE, M_SKIP, M_FLUSH, M_EOLNEXT, M_ERR3
    } t_mode;
    typedef enum logic [1:0] {P_ITEM, P_RUN, P_FIN} t_phase;
    typedef enum logic [1:0] {CM_TEXT, CM_BLOCK, CM_LINE} t_cm;

    typedef struct packed {
        logic [4:0]            kind;
        logic [7:0]            ch;
        logic [VALUE_BITS-1:0] val;
        logic                  ovf;
        logic [5:0]            len;
        logic [2:0]            err;
    } t_res;

    t_phase                r_ph;
    t_mode                 r_mode, n_mode;
    t_cm                   r_cm, n_cm;
    logic                  r_slash, n_slash, r_star, n_star;
    logic                  r_ev1, n_ev1, has_ev;
    t_item                 r_it;
    logic [7:0]            r_held, n_held;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_ovfs, n_ovfs;
    logic [LEN_W-1:0]      r_count, n_count;
    logic [KW_N-1:0]       r_hits, n_hits;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [7:0]            r_store [MAX_TOKEN_LEN];
    logic                  st_we;
    logic [IDX_W-1:0]      st_wa;
    t_res                  r_hold, e_res, r_out;
    logic                  r_hv, r_ov, r_olast;
    logic                  e_v, cons, out_free, step_go, fin_go, push;

    // current event
    logic [7:0] ev_c;
    logic       ev_eol;
    t_cls       ev_cls;
    assign ev_c   = r_ev1 ? CH_SLASH : r_it.c;
    assign ev_eol = r_ev1 ? 1'b0 : r_it.eol;
    assign ev_cls = r_ev1 ? t_cls'('0) : r_it.cls;

    // identifier byte: keyword filter and position
    logic [LEN_W-1:0] ic_pos;
    logic [KW_N-1:0]  ic_hits;
    always_comb begin
        ic_pos  = (r_mode == M_IDLE) ? '0 : r_count;
        ic_hits = (r_mode == M_IDLE) ? '1 : r_hits;
        for (int k = 0; k < KW_N; k++) begin
            if (ic_pos >= LEN_W'(kw_len(k))
                    || kw_word(k)[47 - 8*ic_pos[2:0] -: 8] != ev_c) begin
                ic_hits[k] = 1'b0;
            end
        end
    end

    // keyword match at end of identifier
    logic       kw_hit;
    logic [3:0] kw_idx;
    always_comb begin
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int k = KW_N - 1; k >= 0; k--) begin
            if (r_hits[k] && r_count == LEN_W'(kw_len(k))) begin
                kw_hit = 1'b1;
                kw_idx = 4'(k);
            end
        end
    end

    // digit accumulate with overflow detect
    logic [VALUE_BITS+3:0] acc_w, acc_n;
    always_comb begin
        acc_w = {4'b0, r_acc};
        case (r_mode)
            M_HEX:   acc_n = (acc_w << 4) + (VALUE_BITS+4)'(ev_cls.hex_val);
            M_BIN:   acc_n = (acc_w << 1) + (VALUE_BITS+4)'(ev_cls.hex_val);
            default: acc_n = (acc_w << 3) + (acc_w << 1) + (VALUE_BITS+4)'(ev_cls.hex_val);
        endcase
    end

    // one step of the token builder
    always_comb begin
        e_v     = 1'b0;
        e_res   = '0;
        n_mode  = r_mode;
        cons    = 1'b1;
        n_held  = r_held;
        n_acc   = r_acc;
        n_ovfs  = r_ovfs;
        n_count = r_count;
        n_hits  = r_hits;
        n_idx   = r_idx;
        st_we   = 1'b0;
        st_wa   = ic_pos[IDX_W-1:0];
        unique case (r_mode)
            M_IDLE: begin
                if (ev_eol) begin
                    e_v = 1'b1; e_res.kind = K_EOL;
                end else if (ev_cls.space) begin
                end else if (ev_c == CH_DQUOTE) begin
                    n_mode = M_STR; n_count = '0;
                end else if (ev_c == CH_SQUOTE) begin
                    n_mode = M_CHOPEN;
                end else if (ev_c == CH_LT || ev_c == CH_EQ || ev_c == CH_BANG
                        || ev_c == CH_GT || ev_c == CH_AMP || ev_c == CH_PIPE) begin
                    n_held = ev_c; n_mode = M_OP;
                end else if (ev_cls.digit) begin
                    n_acc  = VALUE_BITS'(ev_cls.hex_val);
                    n_ovfs = 1'b0;
                    n_mode = (ev_c == CH_ZERO) ? M_ZERO : M_DEC;
                end else if (ev_cls.ident) begin
                    n_hits = ic_hits; st_we = 1'b1;
                    n_count = ic_pos + LEN_W'(1); n_mode = M_IDENT;
                end else begin
                    e_v = 1'b1; e_res.kind = K_SINGLE; e_res.ch = ev_c;
                end
            end
            M_OP: begin
                n_mode = M_IDLE;
                e_v = 1'b1;
                e_res.kind = K_SINGLE;
                if (!ev_eol && ev_c == CH_EQ && r_held == CH_LT)  e_res.kind = K_LE;
                else if (!ev_eol && ev_c == CH_EQ && r_held == CH_EQ) e_res.kind = K_EQ;
                else if (!ev_eol && ev_c == CH_EQ && r_held == CH_BANG) e_res.kind = K_NE;
                else if (!ev_eol && ev_c == CH_EQ && r_held == CH_GT) e_res.kind = K_GE;
                else if (!ev_eol && ev_c == r_held && ev_c == CH_LT) e_res.kind = K_SHL;
                else if (!ev_eol && ev_c == r_held && ev_c == CH_GT) e_res.kind = K_SHR;
                else if (!ev_eol && ev_c == r_held && ev_c == CH_AMP) e_res.kind = K_AND;
                else if (!ev_eol && ev_c == r_held && ev_c == CH_PIPE) e_res.kind = K_OR;
                if (e_res.kind == K_SINGLE) begin
                    e_res.ch = r_held; cons = 1'b0;
                end
            end
            M_ZERO: begin
                if (!ev_eol && (ev_c == "x" || ev_c == "X")) n_mode = M_HEX;
                else if (!ev_eol && (ev_c == "b" || ev_c == "B")) n_mode = M_BIN;
                else begin
                    n_mode = M_DEC; cons = 1'b0;
                end
            end
            M_DEC, M_HEX, M_BIN: begin
                if (!ev_eol && ev_c == CH_UNDER) begin
                end else if (!ev_eol && ((r_mode == M_DEC && ev_cls.digit)
                        || (r_mode == M_HEX && ev_cls.hex_ok)
                        || (r_mode == M_BIN && (ev_c == CH_ZERO || ev_c == CH_ONE)))) begin
                    n_acc = acc_n[VALUE_BITS-1:0];
                    if (acc_n[VALUE_BITS+3:VALUE_BITS] != 4'd0) n_ovfs = 1'b1;
                end else begin
                    e_v = 1'b1; e_res.kind = K_NUMBER;
                    e_res.val = r_acc; e_res.ovf = r_ovfs;
                    n_mode = M_IDLE; cons = 1'b0;
                end
            end
            M_IDENT: begin
                if (!ev_eol && ev_cls.ident) begin
                    if (r_count >= LEN_W'(MAX_TOKEN_LEN)) begin
                        e_v = 1'b1; e_res.kind = K_ERROR; e_res.err = E_IDENT_LEN;
                        n_mode = M_SKIP;
                    end else begin
                        n_hits = ic_hits; st_we = 1'b1; n_count = r_count + LEN_W'(1);
                    end
                end else begin
                    e_v = 1'b1; cons = 1'b0;
                    if (kw_hit) begin
                        e_res.kind = 5'(kw_idx) + 5'd1; n_mode = M_IDLE;
                    end else begin
                        e_res.kind = K_IDENT; e_res.len = 6'(r_count);
                        n_mode = M_FLUSH; n_idx = '0;
                    end
                end
            end
            M_FLUSH: begin
                e_v = 1'b1; e_res.kind = K_TEXT; e_res.ch = r_store[r_idx];
                cons = 1'b0;
                if (LEN_W'(r_idx) + LEN_W'(1) == r_count) n_mode = M_IDLE;
                n_idx = r_idx + IDX_W'(1);
            end
            M_STR: begin
                if (ev_eol) begin
                    e_v = 1'b1; e_res.kind = K_ERROR; e_res.err = E_STR_OPEN;
                    n_mode = M_EOLNEXT; cons = 1'b0;
                end else if (ev_c == CH_DQUOTE) begin
                    e_v = 1'b1; e_res.kind = K_STREND; n_mode = M_IDLE;
                end else if (r_count >= LEN_W'(MAX_TOKEN_LEN)) begin
                    e_v = 1'b1; e_res.kind = K_ERROR; e_res.err = E_STR_LEN;
                    n_mode = M_SKIP;
                end else begin
                    n_count = r_count + LEN_W'(1);
                    if (ev_c == CH_BSLASH) n_mode = M_STRESC;
                    else begin
                        e_v = 1'b1; e_res.kind = K_STRCHAR; e_res.ch = ev_c;
                    end
                end
            end
            M_STRESC: begin
                e_v = 1'b1; e_res.kind = K_STRCHAR;
                if (ev_eol) begin
                    e_res.ch = CH_BSLASH; n_mode = M_ERR3; cons = 1'b0;
                end else begin
                    e_res.ch = escape_of(ev_c); n_mode = M_STR;
                end
            end
            M_ERR3: begin
                e_v = 1'b1; e_res.kind = K_ERROR; e_res.err = E_STR_OPEN;
                n_mode = M_EOLNEXT; cons = 1'b0;
            end
            M_EOLNEXT: begin
                e_v = 1'b1; e_res.kind = K_EOL; n_mode = M_IDLE;
            end
            M_CHOPEN, M_CHESC: begin
                if (ev_eol) begin
                    e_v = 1'b1; e_res.kind = K_ERROR; e_res.err = E_BAD_CHAR;
                    n_mode = M_EOLNEXT; cons = 1'b0;
                end else if (r_mode == M_CHOPEN && ev_c == CH_BSLASH) begin
                    n_mode = M_CHESC;
                end else begin
                    n_acc  = VALUE_BITS'((r_mode == M_CHESC) ? escape_of(ev_c) : ev_c);
                    n_ovfs = 1'b0; n_mode = M_CHCLOSE;
                end
            end
            M_CHCLOSE: begin
                e_v = 1'b1;
                if (!ev_eol && ev_c == CH_SQUOTE) begin
                    e_res.kind = K_NUMBER; e_res.val = r_acc; n_mode = M_IDLE;
                end else begin
                    e_res.kind = K_ERROR; e_res.err = E_BAD_CHAR;
                    n_mode = ev_eol ? M_EOLNEXT : M_SKIP;
                    cons = !ev_eol;
                end
            end
            M_SKIP: begin
                if (ev_eol) begin
                    e_v = 1'b1; e_res.kind = K_EOL; n_mode = M_IDLE;
                end
            end
            default: begin
                n_mode = M_IDLE; cons = 1'b0;
            end
        endcase
    end

    // comment stripping on a fresh word
    logic raw;
    always_comb begin
        raw     = (r_mode >= M_STR && r_mode <= M_SKIP);
        n_cm    = r_cm;
        n_slash = r_slash;
        n_star  = r_star;
        n_ev1   = 1'b0;
        has_ev  = 1'b0;
        if (raw) begin
            has_ev = 1'b1;
        end else if (i_q_item.eol) begin
            if (r_cm == CM_LINE) n_cm = CM_TEXT;
            n_star = 1'b0;
            n_slash = 1'b0;
            n_ev1 = r_slash;
            has_ev = 1'b1;
        end else if (r_cm == CM_LINE) begin
        end else if (r_cm == CM_BLOCK) begin
            if (i_q_item.c == CH_SLASH && r_star) begin
                n_cm = CM_TEXT; n_star = 1'b0;
            end else begin
                n_star = (i_q_item.c == CH_STAR);
            end
        end else if (r_slash) begin
            n_slash = 1'b0;
            if (i_q_item.c == CH_SLASH) n_cm = CM_LINE;
            else if (i_q_item.c == CH_STAR) begin
                n_cm = CM_BLOCK; n_star = 1'b0;
            end else begin
                n_ev1 = 1'b1; has_ev = 1'b1;
            end
        end else if (i_q_item.c == CH_SLASH) begin
            n_slash = 1'b1;
        end else begin
            has_ev = 1'b1;
        end
    end

    assign out_free = !r_ov || !i_stall;
    assign step_go  = (r_ph == P_RUN) && (!e_v || !r_hv || out_free);
    assign fin_go   = (r_ph == P_FIN) && (!r_hv || out_free);
    assign push     = (step_go && e_v && r_hv) || (fin_go && r_hv);
    assign o_q_pop  = (r_ph == P_ITEM) && i_q_valid;

    // identifier text store
    always_ff @(posedge i_clk) begin
        if (step_go && st_we) r_store[st_wa] <= ev_c;
    end

    // hold payload, output payload and the latched word
    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_it <= i_q_item;
        if (step_go && e_v) r_hold <= e_res;
        if (push) begin
            r_out   <= r_hold;
            r_olast <= (r_ph == P_FIN);
        end
        if (step_go) begin
            r_held  <= n_held;
            r_acc   <= n_acc;
            r_ovfs  <= n_ovfs;
            r_idx   <= n_idx;
        end
    end

    // sequencer and scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph    <= P_ITEM;
            r_mode  <= M_IDLE;
            r_cm    <= CM_TEXT;
            r_slash <= 1'b0;
            r_star  <= 1'b0;
            r_ev1   <= 1'b0;
            r_count <= '0;
            r_hits  <= '0;
            r_hv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (push) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            unique case (r_ph)
                P_ITEM: begin
                    if (i_q_valid) begin
                        r_cm    <= n_cm;
                        r_slash <= n_slash;
                        r_star  <= n_star;
                        r_ev1   <= n_ev1;
                        if (has_ev) r_ph <= P_RUN;
                    end
                end
                P_RUN: begin
                    if (step_go) begin
                        r_mode  <= n_mode;
                        r_count <= n_count;
                        r_hits  <= n_hits;
                        if (e_v) r_hv <= 1'b1;
                        if (cons) begin
                            if (r_ev1) r_ev1 <= 1'b0;
                            else r_ph <= P_FIN;
                        end
                    end
                end
                P_FIN: begin
                    if (fin_go) begin
                        r_hv <= 1'b0;
                        r_ph <= P_ITEM;
                    end
                end
                default: r_ph <= P_ITEM;
            endcase
        end
    end

    assign o_valid           = r_ov;
    assign o_token_kind      = r_out.kind;
    assign o_char_code       = r_out.ch;
    assign o_number_value    = r_out.val;
    assign o_number_overflow = r_out.ovf;
    assign o_text_length     = r_out.len;
    assign o_error_code      = r_out.err;
    assign o_last_result     = r_olast;

    a_no_transient_between_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ph == P_ITEM |-> !(r_mode == M_FLUSH || r_mode == M_EOLNEXT || r_mode == M_ERR3))
        else $error("scanner left an unfinished sequence between words");
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LEN_W'(MAX_TOKEN_LEN))
        else $error("text count beyond token limit");
    a_flush_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == M_FLUSH |-> LEN_W'(r_idx) < r_count)
        else $error("text flush index past identifier end");
    a_hold_empty_on_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ph == P_ITEM |-> !r_hv)
        else $error("held result not delivered before next word");

endmodule
